[rtl/assert_macros.svh]
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sse_pkg.sv]
// types, constants and control store of the selection sort engine
package sse_pkg;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STEP_W       = 4;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflowed;
  } res_t;

  // read address select
  typedef enum logic [1:0] {
    RD_FRONT,
    RD_SCAN,
    RD_SCAN_NEXT,
    RD_OUT
  } rd_sel_e;

  // write port select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_BEST,
    WR_FRONT
  } wr_sel_e;

  // jump conditions
  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_WAIT,
    JMP_SORTED,
    JMP_SCAN_MORE,
    JMP_NO_SWAP,
    JMP_OUT_MORE
  } jump_e;

  typedef struct packed {
    rd_sel_e           rd_sel;
    wr_sel_e           wr_sel;
    logic              pass_init;
    logic              take_front;
    logic              scan_cmp;
    logic              front_inc;
    logic              out_inc;
    logic              emit;
    logic              clear;
    jump_e             jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // program steps
  localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] ST_PASS     = 4'd1;
  localparam logic [STEP_W-1:0] ST_FRONT    = 4'd2;
  localparam logic [STEP_W-1:0] ST_SCAN     = 4'd3;
  localparam logic [STEP_W-1:0] ST_SWAP_A   = 4'd4;
  localparam logic [STEP_W-1:0] ST_SWAP_B   = 4'd5;
  localparam logic [STEP_W-1:0] ST_NEXT     = 4'd6;
  localparam logic [STEP_W-1:0] ST_OUT_INIT = 4'd7;
  localparam logic [STEP_W-1:0] ST_OUT      = 4'd8;
  localparam logic [STEP_W-1:0] ST_DONE     = 4'd9;

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w        = '0;
    w.rd_sel = RD_FRONT;
    w.wr_sel = WR_NONE;
    w.jump   = JMP_NONE;
    w.target = ST_IDLE;
    case (step)
      ST_IDLE: begin
        w.wr_sel = WR_LOAD;
        w.jump   = JMP_WAIT;
        w.target = ST_IDLE;
      end
      ST_PASS: begin
        w.rd_sel    = RD_FRONT;
        w.pass_init = 1'b1;
        w.jump      = JMP_SORTED;
        w.target    = ST_OUT_INIT;
      end
      ST_FRONT: begin
        w.rd_sel     = RD_SCAN;
        w.take_front = 1'b1;
      end
      ST_SCAN: begin
        w.rd_sel   = RD_SCAN_NEXT;
        w.scan_cmp = 1'b1;
        w.jump     = JMP_SCAN_MORE;
        w.target   = ST_SCAN;
      end
      ST_SWAP_A: begin
        w.wr_sel = WR_BEST;
        w.jump   = JMP_NO_SWAP;
        w.target = ST_NEXT;
      end
      ST_SWAP_B: begin
        w.wr_sel = WR_FRONT;
      end
      ST_NEXT: begin
        w.front_inc = 1'b1;
        w.jump      = JMP_ALWAYS;
        w.target    = ST_PASS;
      end
      ST_OUT_INIT: begin
        w.rd_sel  = RD_OUT;
        w.out_inc = 1'b1;
      end
      ST_OUT: begin
        w.rd_sel  = RD_OUT;
        w.out_inc = 1'b1;
        w.emit    = 1'b1;
        w.jump    = JMP_OUT_MORE;
        w.target  = ST_OUT;
      end
      ST_DONE: begin
        w.clear  = 1'b1;
        w.jump   = JMP_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.jump   = JMP_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/selection_sort_engine_unit.sv]
// selection sort engine top level: element store, microcoded sequencer, result strobe
// loading: one request per cycle; busy is low while loading
// a set of n kept elements is sorted with one compare a cycle (bounded by the single
// read port of the element store), then emitted in sorted order
// results appear one per cycle with res_valid_o; the receiver cannot stall
// reset (asynchronous, active low) clears the sequencer, indices, count, overflow flag
// and result strobe; the element store and working registers are left as they are
module selection_sort_engine_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  sse_pkg::req_t req_i,
  output logic          busy,
  output logic          res_valid_o,
  output sse_pkg::res_t res_o
);
  import sse_pkg::*;

  `include "assert_macros.svh"

  // sequencer state
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uw;

  // datapath registers
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     ovf_q, ovf_d;
  logic [IDX_W-1:0]         front_q, front_d;
  logic [CNT_W-1:0]         scan_q, scan_d;
  logic [IDX_W-1:0]         best_q, best_d;
  logic signed [DATA_W-1:0] min_q, min_d;
  logic signed [DATA_W-1:0] front_val_q, front_val_d;
  logic [CNT_W-1:0]         out_q, out_d;
  logic                     res_valid_q, res_valid_d;
  res_t                     res_q, res_d;

  // element store: one write and one registered read a cycle
  logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] rdata_q;
  logic [IDX_W-1:0]         raddr;
  logic [IDX_W-1:0]         waddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     wen;

  logic             accept;
  logic             room;
  logic [CNT_W-1:0] front_p1;
  logic [CNT_W-1:0] scan_p1;
  logic             taken;
  logic             smaller;

  assign uw       = ucode_rom(step_q);
  assign busy     = (step_q != ST_IDLE);
  assign accept   = start && !busy;
  assign room     = (cnt_q < CNT_W'(MAX_ELEMENTS));
  assign front_p1 = CNT_W'(front_q) + CNT_W'(1);
  assign scan_p1  = scan_q + CNT_W'(1);
  // first strictly smaller value wins, so equal values keep the earlier index
  assign smaller  = (rdata_q < min_q);

  // read address mux
  always_comb begin
    case (uw.rd_sel)
      RD_FRONT:     raddr = front_q;
      RD_SCAN:      raddr = front_p1[IDX_W-1:0];
      RD_SCAN_NEXT: raddr = scan_p1[IDX_W-1:0];
      RD_OUT:       raddr = out_q[IDX_W-1:0];
      default:      raddr = front_q;
    endcase
  end

  // write port mux: loading, then the two halves of a swap
  always_comb begin
    wen   = 1'b0;
    waddr = cnt_q[IDX_W-1:0];
    wdata = req_i.value;
    case (uw.wr_sel)
      WR_LOAD: begin
        wen   = accept && room;
        waddr = cnt_q[IDX_W-1:0];
        wdata = req_i.value;
      end
      WR_BEST: begin
        wen   = (best_q != front_q);
        waddr = best_q;
        wdata = front_val_q;
      end
      WR_FRONT: begin
        wen   = 1'b1;
        waddr = front_q;
        wdata = min_q;
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // jump condition evaluation
  always_comb begin
    case (uw.jump)
      JMP_NONE:      taken = 1'b0;
      JMP_ALWAYS:    taken = 1'b1;
      JMP_WAIT:      taken = !(accept && req_i.last);
      JMP_SORTED:    taken = (front_p1 >= cnt_q);
      JMP_SCAN_MORE: taken = (scan_p1 < cnt_q);
      JMP_NO_SWAP:   taken = (best_q == front_q);
      JMP_OUT_MORE:  taken = (out_q != cnt_q);
      default:       taken = 1'b1;
    endcase
    step_d = taken ? uw.target : step_q + STEP_W'(1);
  end

  // datapath driven by the current control word
  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    front_d     = front_q;
    scan_d      = scan_q;
    best_d      = best_q;
    min_d       = min_q;
    front_val_d = front_val_q;
    out_d       = out_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    // store a request, or note that it was dropped
    if (uw.wr_sel == WR_LOAD && accept) begin
      if (room) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    // start of a pass: front is the first candidate
    if (uw.pass_init) begin
      best_d = front_q;
      scan_d = front_p1;
    end

    // front value arrives from the store
    if (uw.take_front) begin
      min_d       = rdata_q;
      front_val_d = rdata_q;
    end

    // one compare per cycle
    if (uw.scan_cmp) begin
      if (smaller) begin
        min_d  = rdata_q;
        best_d = scan_q[IDX_W-1:0];
      end
      scan_d = scan_p1;
    end

    if (uw.front_inc) begin
      front_d = front_q + IDX_W'(1);
    end

    if (uw.out_inc) begin
      out_d = out_q + CNT_W'(1);
    end

    // result for the element read in the previous step
    if (uw.emit) begin
      res_valid_d        = 1'b1;
      res_d.sorted_value = rdata_q;
      res_d.end_of_set   = (out_q == cnt_q);
      res_d.overflowed   = ovf_q;
    end

    // set finished
    if (uw.clear) begin
      cnt_d   = '0;
      ovf_d   = 1'b0;
      front_d = '0;
      out_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      front_q     <= '0;
      out_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      front_q     <= front_d;
      out_q       <= out_d;
      res_valid_q <= res_valid_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    best_q      <= best_d;
    min_q       <= min_d;
    front_val_q <= front_val_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // results only leave while the engine is working on a set
  `ASSERT_SAME(a_res_while_busy, clk_i, rst_ni, res_valid_o, busy)
  // the last result of a set returns the engine to idle next cycle
  `ASSERT_NEXT(a_idle_after_end, clk_i, rst_ni, res_valid_o && res_o.end_of_set, !busy)
  // a closing request always starts the sort
  `ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, start && !busy && req_i.last, busy)
  // the element count never passes the store depth
  `ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(MAX_ELEMENTS))

endmodule

[dv/selection_sort_engine_unit_test.sv]
// self-checking testbench for the selection sort engine: directed and random sets
`timescale 1ns / 1ps

module selection_sort_engine_unit_test;
  import sse_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  // elements of the set being collected, as the block should hold them
  logic signed [DATA_W-1:0] held_elements[$];
  logic                     held_dropped;
  // sorted results still owed by the block, oldest first
  res_t                     owed_sorted[$];

  int unsigned failures;
  int unsigned requests_sent;
  int unsigned sets_closed;
  int unsigned overflow_sets;
  int unsigned results_checked;
  bit          gaps_on;

  selection_sort_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what);
    failures++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // update the held set with one accepted request; on last, sort and queue the results
  task automatic predict_sorted_set(input req_t r);
    logic signed [DATA_W-1:0] ordered[$];
    logic signed [DATA_W-1:0] swap_hold;
    res_t                     entry;
    int                       lo;
    if (held_elements.size() < MAX_ELEMENTS) begin
      held_elements.push_back(r.value);
    end else begin
      held_dropped = 1'b1;
    end
    if (!r.last) return;
    ordered = held_elements;
    // selection sort: first strictly smaller minimum goes to the front
    for (int front = 0; front + 1 < ordered.size(); front++) begin
      lo = front;
      for (int scan = front + 1; scan < ordered.size(); scan++) begin
        if (ordered[scan] < ordered[lo]) lo = scan;
      end
      if (lo != front) begin
        swap_hold     = ordered[front];
        ordered[front] = ordered[lo];
        ordered[lo]    = swap_hold;
      end
    end
    foreach (ordered[k]) begin
      entry.sorted_value = ordered[k];
      entry.end_of_set   = (k == ordered.size() - 1);
      entry.overflowed   = held_dropped;
      owed_sorted.push_back(entry);
    end
    sets_closed++;
    if (held_dropped) overflow_sets++;
    held_elements.delete();
    held_dropped = 1'b0;
  endtask

  // result checker: every strobe must match the oldest owed result
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (owed_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d", res_o.sorted_value));
      end else begin
        want = owed_sorted.pop_front();
        results_checked++;
        if (res_o.sorted_value !== want.sorted_value)
          report_mismatch($sformatf("sorted_value got %0d want %0d",
                                    res_o.sorted_value, want.sorted_value));
        if (res_o.end_of_set !== want.end_of_set)
          report_mismatch($sformatf("end_of_set got %b want %b",
                                    res_o.end_of_set, want.end_of_set));
        if (res_o.overflowed !== want.overflowed)
          report_mismatch($sformatf("overflowed got %b want %b",
                                    res_o.overflowed, want.overflowed));
      end
    end
  end

  // send one request; called at a falling edge, returns at a falling edge
  task automatic send_request(input logic signed [DATA_W-1:0] v, input logic l);
    req_t r;
    r.value = v;
    r.last  = l;
    start <= 1'b1;
    req_i <= r;
    // busy is sampled before the edge updates it
    do @(posedge clk_i); while (busy);
    predict_sorted_set(r);
    requests_sent++;
    @(negedge clk_i);
    // random sender idling, about a third of the cycles
    if (gaps_on) begin
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  // send a whole set, last flag on the final element
  task automatic send_set(input logic signed [DATA_W-1:0] vals[$]);
    foreach (vals[i]) send_request(vals[i], i == vals.size() - 1);
  endtask

  // hold the sender off until every owed result has come back
  task automatic wait_all_sorted();
    start <= 1'b0;
    while (owed_sorted.size() != 0) @(negedge clk_i);
  endtask

  // mix of wide random values, clustered small values (duplicates) and edge values
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned mode;
    logic signed [DATA_W-1:0] v;
    mode = $urandom_range(9);
    if (mode < 5) v = $urandom;
    else if (mode < 8) v = $urandom_range(8) - 4;
    else if (mode == 8) begin
      case ($urandom_range(3))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = '0;
        default: v = '1;
      endcase
    end else begin
      v = $urandom_range(1) ? 32'sh8000_0000 + $urandom_range(3)
                            : 32'sh7fff_ffff - $urandom_range(3);
    end
    return v;
  endfunction

  // one-element sets at the extremes of the value range and at zero
  task automatic test_single_elements();
    send_set('{32'sh8000_0000});
    send_set('{32'sh7fff_ffff});
    send_set('{32'sh0});
  endtask

  // extremes mixed, repeated minima, already ordered and reversed sets
  task automatic test_ordering_cases();
    send_set('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1,
               32'sh8000_0001, 32'sh7fff_fffe});
    send_set('{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3});
    send_set('{32'sd1, 32'sd2, 32'sd3, 32'sd4});
    send_set('{32'sd4, 32'sd3, 32'sd2, 32'sd1});
  endtask

  // exactly a full store, then a pause until every result is back
  task automatic test_full_store();
    logic signed [DATA_W-1:0] vals[$];
    for (int i = 0; i < MAX_ELEMENTS; i++) vals.push_back((MAX_ELEMENTS - i) / 2);
    send_set(vals);
    wait_all_sorted();
  endtask

  // store overflow: dropped element carrying last, then a single dropped element
  task automatic test_store_overflow();
    logic signed [DATA_W-1:0] vals[$];
    for (int i = 0; i < MAX_ELEMENTS + 6; i++) vals.push_back(pick_value());
    send_set(vals);
    vals.delete();
    for (int i = 0; i < MAX_ELEMENTS + 1; i++) vals.push_back(pick_value());
    send_set(vals);
    // a small set afterwards must come back without the overflow flag
    send_set('{32'sd7, -32'sd7});
  endtask

  // random sets, mostly short; a long stretch in the middle runs without gaps
  task automatic test_random_sets(input int unsigned quota);
    logic signed [DATA_W-1:0] vals[$];
    int unsigned first;
    int unsigned size_pick;
    int unsigned set_size;
    first = requests_sent;
    while (requests_sent - first < quota) begin
      gaps_on = !((requests_sent - first) inside {[quota / 3 : quota / 2]});
      size_pick = $urandom_range(99);
      if (size_pick < 70) set_size = $urandom_range(1, 8);
      else if (size_pick < 90) set_size = $urandom_range(9, 24);
      else if (size_pick < 97) set_size = $urandom_range(25, MAX_ELEMENTS);
      else set_size = $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 8);
      vals.delete();
      repeat (set_size) vals.push_back(pick_value());
      send_set(vals);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    // every input known from time zero
    start         = 1'b0;
    req_i         = '0;
    rst_ni        = 1'b0;
    held_dropped  = 1'b0;
    failures      = 0;
    requests_sent = 0;
    sets_closed   = 0;
    overflow_sets = 0;
    results_checked = 0;
    gaps_on       = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_elements();
    test_ordering_cases();
    test_full_store();
    test_store_overflow();
    test_random_sets(280);

    // drain, then give the sequencer time to settle
    wait_all_sorted();
    repeat (50) @(negedge clk_i);

    $display("sent %0d requests in %0d sets (%0d with dropped elements), %0d results checked",
             requests_sent, sets_closed, overflow_sets, results_checked);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[selection_sort_engine_unit.f]
+incdir+rtl
rtl/sse_pkg.sv
rtl/selection_sort_engine_unit.sv
dv/selection_sort_engine_unit_test.sv
